>>> sv/ssnd_pkg.sv
// Shared types and constants for the servo scan nearest-distance controller.
// No dependencies; every other file in this folder but ssnd_ram imports it.
package ssnd_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int TAB_AW      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int ANGLE_W    = 10;
	localparam int DIST_W     = 16;
	localparam int KIND_W     = 2;
	localparam int MODE_W     = 2;
	localparam int PASS_W     = 2;
	localparam int TAB_W      = ANGLE_W + DIST_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ANG  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd6;

	localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 10'd180;
	localparam logic [ANGLE_W-1:0] STEP_RST      = 10'd1;

	// operating modes; the fourth code has no meaning
	localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RANGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd2;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_MEAS  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TELEM  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

	localparam logic [PASS_W-1:0] PASS_DONE = 2'd2;
	localparam logic [PASS_W-1:0] PASS_MAX  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MOVE,
		ST_SEARCH,
		ST_DRAIN,
		ST_BEST_MOVE,
		ST_BEST_REPORT
	} ssnd_state_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_START,
		EMIT_TELEM,
		EMIT_MOVE,
		EMIT_BEST_MOVE,
		EMIT_BEST_TELEM
	} ssnd_emit_t;

	typedef struct packed {
		logic       latch;
		logic       start_apply;
		ssnd_emit_t emit;
		logic       last;
		logic       sweep;
		logic       store;
		logic       count_pass;
		logic       stop;
		logic       search_clear;
		logic       search_read;
		logic       best_take;
	} ssnd_cmd_t;

	typedef struct packed {
		logic              action;
		logic              running;
		logic [MODE_W-1:0] mode;
		logic              pass_done;
		logic              search_end;
	} ssnd_stat_t;

endpackage

>>> sv/ssnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/ssnd_ctrl.sv
// Sequencing state machine of the servo scan controller.
// Depends on ssnd_pkg; drives the datapath through ssnd_cmd_t.
module ssnd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ssnd_pkg::ssnd_stat_t stat,
	output ssnd_pkg::ssnd_cmd_t  cmd
);

	import ssnd_pkg::*;

	ssnd_state_t state_q;
	ssnd_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_nx = ST_IDLE;
				if (stat.action == ACT_MEAS && stat.running) begin
					if (stat.mode == MODE_RANGE) begin
						state_nx = ST_MOVE;
					end else if (stat.mode == MODE_SCAN) begin
						state_nx = stat.pass_done ? ST_SEARCH : ST_MOVE;
					end
				end
			end
			ST_MOVE:        state_nx = ST_IDLE;
			ST_SEARCH: begin
				if (stat.search_end) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN:       state_nx = ST_BEST_MOVE;
			ST_BEST_MOVE:   state_nx = ST_BEST_REPORT;
			ST_BEST_REPORT: state_nx = ST_IDLE;
			default:        state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.latch = start;
			end
			ST_EVAL: begin
				if (stat.action == ACT_START) begin
					cmd.start_apply = 1'b1;
					cmd.emit        = EMIT_START;
					cmd.last        = 1'b1;
				end else if (stat.running) begin
					case (stat.mode)
						MODE_FIXED: begin
							cmd.emit = EMIT_TELEM;
							cmd.last = 1'b1;
						end
						MODE_RANGE: begin
							cmd.emit  = EMIT_TELEM;
							cmd.sweep = 1'b1;
						end
						MODE_SCAN: begin
							cmd.store      = 1'b1;
							cmd.sweep      = 1'b1;
							cmd.count_pass = 1'b1;
							if (stat.pass_done) begin
								cmd.stop         = 1'b1;
								cmd.search_clear = 1'b1;
							end
						end
						default: begin
							// drop the measurement
							cmd.emit = EMIT_NONE;
						end
					endcase
				end
			end
			ST_MOVE: begin
				cmd.emit = EMIT_MOVE;
				cmd.last = 1'b1;
			end
			ST_SEARCH: begin
				cmd.search_read = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_BEST_MOVE: begin
				cmd.emit      = EMIT_BEST_MOVE;
				cmd.best_take = 1'b1;
			end
			ST_BEST_REPORT: begin
				cmd.emit = EMIT_BEST_TELEM;
				cmd.last = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> sv/ssnd_dp.sv
// Datapath: configuration registers, sweep arithmetic, scan table, best-match
// search and result registers. Depends on ssnd_pkg and ssnd_ram.
module ssnd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr,
	input  logic [ssnd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssnd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              action,
	input  logic [ssnd_pkg::DIST_W-1:0]       measured_distance,
	input  ssnd_pkg::ssnd_cmd_t               cmd,
	output ssnd_pkg::ssnd_stat_t              stat,
	output logic                              strobe,
	output logic [ssnd_pkg::KIND_W-1:0]       kind,
	output logic [ssnd_pkg::ANGLE_W-1:0]      angle,
	output logic [ssnd_pkg::DIST_W-1:0]       distance,
	output logic                              last
);

	import ssnd_pkg::*;

	// configuration
	logic [MODE_W-1:0]  mode_q;
	logic [ANGLE_W-1:0] angle_a_q, angle_b_q, min_q, max_q, step_q;
	logic [DIST_W-1:0]  target_q;

	// scan state
	logic               running_q;
	logic [ANGLE_W-1:0] cur_q, rlo_q, rhi_q;
	logic               down_q;
	logic [PASS_W-1:0]  pass_q;
	logic [CNT_W-1:0]   cnt_q;

	// latched item
	logic               action_q;
	logic [DIST_W-1:0]  meas_q;

	// search
	logic [TAB_AW-1:0]  idx_q;
	logic               rd_valid_s1, rd_first_s1;
	logic [TAB_W-1:0]   rd_data;
	logic [ANGLE_W-1:0] best_ang_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [DIST_W-1:0]  near_gap_q;

	// result registers
	logic               strobe_q, last_q;
	logic [KIND_W-1:0]  kind_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [DIST_W-1:0]  dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FIXED;
			angle_a_q <= '0;
			angle_b_q <= '0;
			target_q  <= '0;
			min_q     <= '0;
			max_q     <= MAX_ANGLE_RST;
			step_q    <= STEP_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_MODE:    mode_q    <= cfg_data[MODE_W-1:0];
				REG_ANGLE_A: angle_a_q <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_B: angle_b_q <= cfg_data[ANGLE_W-1:0];
				REG_TARGET:  target_q  <= cfg_data[DIST_W-1:0];
				REG_MIN_ANG: min_q     <= cfg_data[ANGLE_W-1:0];
				REG_MAX_ANG: max_q     <= cfg_data[ANGLE_W-1:0];
				REG_STEP:    step_q    <= cfg_data[ANGLE_W-1:0];
				default:     mode_q    <= mode_q;
			endcase
		end
	end

	// start checks
	logic               start_ok;
	logic [ANGLE_W-1:0] lo_ab, hi_ab, start_ang;

	always_comb begin
		lo_ab     = (angle_a_q < angle_b_q) ? angle_a_q : angle_b_q;
		hi_ab     = (angle_a_q < angle_b_q) ? angle_b_q : angle_a_q;
		start_ok  = 1'b0;
		start_ang = angle_a_q;
		case (mode_q)
			MODE_FIXED: begin
				start_ok = (angle_a_q <= max_q);
			end
			MODE_RANGE: begin
				start_ok  = (angle_a_q <= max_q) && (angle_b_q <= max_q);
				start_ang = lo_ab;
			end
			MODE_SCAN: begin
				start_ok  = (target_q != '0);
				start_ang = min_q;
			end
			default: begin
				start_ok = 1'b0;
			end
		endcase
	end

	// one ping-pong step
	logic [ANGLE_W-1:0] sw_lo, sw_hi, sw_ang;
	logic [ANGLE_W:0]   up_sum, lo_sum;
	logic               sw_down, sw_clamp;
	logic [PASS_W-1:0]  pass_nx;

	always_comb begin
		sw_lo    = (mode_q == MODE_RANGE) ? rlo_q : min_q;
		sw_hi    = (mode_q == MODE_RANGE) ? rhi_q : max_q;
		up_sum   = {1'b0, cur_q} + {1'b0, step_q};
		lo_sum   = {1'b0, sw_lo} + {1'b0, step_q};
		sw_ang   = cur_q;
		sw_down  = down_q;
		sw_clamp = 1'b0;
		if (!down_q) begin
			if (up_sum >= {1'b0, sw_hi}) begin
				sw_ang   = sw_hi;
				sw_down  = 1'b1;
				sw_clamp = 1'b1;
			end else begin
				sw_ang = up_sum[ANGLE_W-1:0];
			end
		end else begin
			if ({1'b0, cur_q} <= lo_sum) begin
				sw_ang   = sw_lo;
				sw_down  = 1'b0;
				sw_clamp = 1'b1;
			end else begin
				sw_ang = cur_q - step_q;
			end
		end
		pass_nx = pass_q;
		if (sw_clamp && pass_q < PASS_MAX) begin
			pass_nx = pass_q + PASS_W'(1);
		end
	end

	logic tab_full;
	logic tab_we;

	assign tab_full = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign tab_we   = cmd.store && !tab_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cur_q     <= '0;
			rlo_q     <= '0;
			rhi_q     <= '0;
			down_q    <= 1'b0;
			pass_q    <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.start_apply) begin
				running_q <= start_ok;
				if (start_ok) begin
					cur_q <= start_ang;
					if (mode_q == MODE_RANGE) begin
						rlo_q  <= lo_ab;
						rhi_q  <= hi_ab;
						down_q <= 1'b0;
					end
					if (mode_q == MODE_SCAN) begin
						cnt_q  <= '0;
						pass_q <= '0;
						down_q <= 1'b0;
					end
				end
			end
			if (cmd.sweep) begin
				cur_q  <= sw_ang;
				down_q <= sw_down;
			end
			if (cmd.count_pass) begin
				pass_q <= pass_nx;
			end
			if (tab_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.stop) begin
				running_q <= 1'b0;
			end
			if (cmd.best_take) begin
				cur_q <= best_ang_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= action;
			meas_q   <= measured_distance;
		end
	end

	ssnd_ram #(
		.WIDTH (TAB_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (cnt_q[TAB_AW-1:0]),
		.wdata ({cur_q, meas_q}),
		.re    (cmd.search_read),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.search_read;
			rd_first_s1 <= cmd.search_read && (idx_q == '0);
			if (cmd.search_clear) begin
				idx_q <= '0;
			end else if (cmd.search_read) begin
				idx_q <= idx_q + TAB_AW'(1);
			end
		end
	end

	// compare the entry that came back from the table; strict less keeps the earliest tie
	logic [DIST_W-1:0] rd_dist, rd_diff;
	logic              take_entry;

	always_comb begin
		rd_dist    = rd_data[DIST_W-1:0];
		rd_diff    = (rd_dist >= target_q) ? (rd_dist - target_q) : (target_q - rd_dist);
		take_entry = rd_valid_s1 && (rd_first_s1 || (rd_diff < near_gap_q));
	end

	always_ff @(posedge clk) begin
		if (take_entry) begin
			near_gap_q  <= rd_diff;
			best_dist_q <= rd_dist;
			best_ang_q  <= rd_data[TAB_W-1:DIST_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.emit != EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EMIT_NONE) begin
			last_q <= cmd.last;
		end
		case (cmd.emit)
			EMIT_START: begin
				kind_q  <= start_ok ? KIND_MOVE : KIND_REJECT;
				angle_q <= start_ok ? start_ang : '0;
				dist_q  <= '0;
			end
			EMIT_TELEM: begin
				kind_q  <= KIND_TELEM;
				angle_q <= cur_q;
				dist_q  <= meas_q;
			end
			EMIT_MOVE: begin
				kind_q  <= KIND_MOVE;
				angle_q <= cur_q;
				dist_q  <= '0;
			end
			EMIT_BEST_MOVE: begin
				kind_q  <= KIND_MOVE;
				angle_q <= best_ang_q;
				dist_q  <= '0;
			end
			EMIT_BEST_TELEM: begin
				kind_q  <= KIND_TELEM;
				angle_q <= best_ang_q;
				dist_q  <= best_dist_q;
			end
			default: begin
				kind_q <= kind_q;
			end
		endcase
	end

	always_comb begin
		stat.action     = action_q;
		stat.running    = running_q;
		stat.mode       = mode_q;
		stat.pass_done  = (pass_nx >= PASS_DONE);
		stat.search_end = ({1'b0, idx_q} == ((TAB_AW + 1)'(cnt_q) - (TAB_AW + 1)'(1)));
	end

	assign strobe   = strobe_q;
	assign kind     = kind_q;
	assign angle    = angle_q;
	assign distance = dist_q;
	assign last     = last_q;

endmodule

>>> sv/servo_scan_nearest_distance.sv
// Top level of the servo scan nearest-distance controller.
// Depends on ssnd_pkg, ssnd_ctrl, ssnd_dp (which holds ssnd_ram).
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item's last result has been issued. Each result shows on kind,
// angle, distance and last for exactly one cycle with strobe high, and the
// receiver has to take it then. A start or a fixed-mode measurement gives its
// single result from a register set in the evaluation state; a range-mode
// measurement gives a report from the evaluation state and then a move from
// the move state. A scan-mode measurement that ends the second pass walks the
// scan table one entry per cycle through the table's single read port; after a
// drain state the move to the best angle and then the report follow. The table
// holds at most 512 stored entries. Configuration writes go in only while no
// item is in flight is a rule for the user; the block itself does not enforce it.
module servo_scan_nearest_distance (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [ssnd_pkg::DIST_W-1:0]      measured_distance,
	input  logic                             cfg_wr,
	input  logic [ssnd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssnd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             strobe,
	output logic [ssnd_pkg::KIND_W-1:0]      kind,
	output logic [ssnd_pkg::ANGLE_W-1:0]     angle,
	output logic [ssnd_pkg::DIST_W-1:0]      distance,
	output logic                             last
);

	import ssnd_pkg::*;

	ssnd_cmd_t  cmd;
	ssnd_stat_t stat;

	ssnd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	ssnd_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr            (cfg_wr),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.action            (action),
		.measured_distance (measured_distance),
		.cmd               (cmd),
		.stat              (stat),
		.strobe            (strobe),
		.kind              (kind),
		.angle             (angle),
		.distance          (distance),
		.last              (last)
	);

`ifndef SYNTHESIS
	// busy is high in the cycle after a transfer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after a transfer");

	// every result comes from work done while busy
	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result issued without an item in flight");

	// a result that is not the last one is followed at once by another
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("result burst broken");

	// a reject is a single result with no angle
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_REJECT |-> last && angle == '0 && distance == '0)
		else $error("malformed reject result");
`endif

endmodule
